FILE: rtl/core/pip_pkg.sv
// Shared types, constants and codes for the point-in-polygon tester.
package pip_pkg;

   // Vertex table geometry.
   localparam int MAX_VERTICES = 64;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

   // One stored vertex is x in the upper half and y in the lower half.
   localparam int COORD_W  = 16;
   localparam int VERTEX_W = 2 * COORD_W;

   // Command queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic CSR_IDX_CLOSED = 1'b0;

   // Function codes carried on the request.
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;
   localparam logic [1:0] FUNC_NONE  = 2'd3;

   // Decoded operation handed from the front end to the back end.
   typedef enum logic [3:0] {
      OP_ADD   = 4'b0001,
      OP_CLEAR = 4'b0010,
      OP_QUERY = 4'b0100,
      OP_NOP   = 4'b1000
   } op_type;

   typedef struct packed {
      logic [1:0]                 func;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic status;
   } rsp_type;

   typedef struct packed {
      op_type                     op;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
   } cmd_type;

endpackage

FILE: rtl/core/point_in_polygon_test_top.sv
// Top level of the point-in-polygon tester: configuration port, front end and back end.
// Add, clear and unused commands are answered from the idle state through the result
// register. A query on a closed polygon of n >= 2 vertices occupies the back end while
// it reads the vertex table through its single read port (one vertex per cycle), forms
// the closing edge and drains the two-stage crossing pipeline.
// A two-entry command queue accepts new requests while the back end works; results
// are single-cycle strobes. Synchronous reset empties the table and clears closed.
module point_in_polygon_test_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  pip_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output pip_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pip_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pip_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pip_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   logic             closed_ff, closed_in;
   logic             csr_write;
   logic             cmd_valid;
   logic             cmd_ready;
   pip_pkg::cmd_type cmd;

   // Configuration register: word address selects the register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign closed_in = (csr_write && paddr[2] == pip_pkg::CSR_IDX_CLOSED) ? pwdata[0]
                                                                          : closed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff <= 1'b0;
      end else begin
         closed_ff <= closed_in;
      end
   end

   // Read back.
   always_comb begin
      prdata = '0;
      if (paddr[2] == pip_pkg::CSR_IDX_CLOSED) begin
         prdata[0] = closed_ff;
      end
   end

   pip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   pip_back u_back (
      .clock     (clock),
      .reset     (reset),
      .closed    (closed_ff),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

FILE: rtl/core/pip_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/pip_front.sv
// Front end: accepts requests, decodes the function code and queues commands.
module pip_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pip_pkg::req_type  req_data,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output pip_pkg::cmd_type  cmd
);

   pip_pkg::cmd_type                entries_ff [pip_pkg::QUEUE_DEPTH];
   logic [pip_pkg::Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [pip_pkg::Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [pip_pkg::Q_CNT_W-1:0]     fill_ff, fill_in;
   pip_pkg::cmd_type                decoded;
   logic                            push;
   logic                            pop;

   // Decode the function code into an operation.
   always_comb begin
      decoded.x = req_data.x;
      decoded.y = req_data.y;
      unique case (req_data.func)
         pip_pkg::FUNC_ADD:   decoded.op = pip_pkg::OP_ADD;
         pip_pkg::FUNC_CLEAR: decoded.op = pip_pkg::OP_CLEAR;
         pip_pkg::FUNC_QUERY: decoded.op = pip_pkg::OP_QUERY;
         pip_pkg::FUNC_NONE:  decoded.op = pip_pkg::OP_NOP;
      endcase
   end

   // The queue is full when every entry holds a pending command.
   assign busy      = (fill_ff == pip_pkg::Q_CNT_W'(pip_pkg::QUEUE_DEPTH));
   assign push      = start && !busy;
   assign cmd_valid = (fill_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = entries_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

FILE: rtl/core/pip_back.sv
// Back end: vertex table, edge walk with crossing test, and result register.
module pip_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              closed,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  pip_pkg::cmd_type  cmd,
   output logic              rsp_valid,
   output pip_pkg::rsp_type  rsp
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_WALK  = 5'b00010,
      S_CLOSE = 5'b00100,
      S_WRAP  = 5'b01000,
      S_DRAIN = 5'b10000
   } state_type;

   localparam int CW = pip_pkg::COORD_W;

   state_type                   state_ff, state_in;
   logic [pip_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [pip_pkg::IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                        rd_pend_ff, rd_pend_in;
   logic                        rd_first_ff, rd_first_in;
   logic signed [CW-1:0]        px_ff, px_in, py_ff, py_in;
   logic signed [CW-1:0]        first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [CW-1:0]        prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                        edge_valid_ff, edge_valid_in;
   logic signed [CW-1:0]        sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic                        prod_valid_ff, prod_valid_in;
   logic                        cross_ff, cross_in;
   logic                        dpos_ff, dpos_in;
   logic signed [2*CW+1:0]      lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic                        flag_ff, flag_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pip_pkg::rsp_type            rsp_ff, rsp_in;

   logic                        wr_en;
   logic                        rd_en;
   logic [pip_pkg::VERTEX_W-1:0] rd_data;
   logic signed [CW-1:0]        rd_x, rd_y;
   logic signed [CW:0]          d_y, d_px, d_ex, d_py;
   logic                        full;
   logic                        hit;

   // Vertex table: one entry holds both coordinates of a vertex.
   pip_ram #(
      .WIDTH (pip_pkg::VERTEX_W),
      .DEPTH (pip_pkg::MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[pip_pkg::IDX_W-1:0]),
      .wr_data ({cmd.x, cmd.y}),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign rd_x = rd_data[pip_pkg::VERTEX_W-1:CW];
   assign rd_y = rd_data[CW-1:0];
   assign full = (count_ff == pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES));

   assign cmd_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // First pipeline stage: straddle test and the two cross products.
   always_comb begin
      d_y  = (CW+1)'(ey_ff) - (CW+1)'(sy_ff);
      d_px = (CW+1)'(px_ff) - (CW+1)'(sx_ff);
      d_ex = (CW+1)'(ex_ff) - (CW+1)'(sx_ff);
      d_py = (CW+1)'(py_ff) - (CW+1)'(sy_ff);
      prod_valid_in = edge_valid_ff;
      cross_in      = (sy_ff > py_ff) != (ey_ff > py_ff);
      dpos_in       = (d_y > (CW+1)'(0));
      lhs_in        = (2*CW+2)'(d_px) * (2*CW+2)'(d_y);
      rhs_in        = (2*CW+2)'(d_ex) * (2*CW+2)'(d_py);
   end

   // Second pipeline stage: the inequality direction follows the sign of the y extent.
   assign hit = prod_valid_ff && cross_ff &&
                (dpos_ff ? (lhs_ff < rhs_ff) : (lhs_ff > rhs_ff));

   // Command sequencing and edge formation.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rd_pend_in    = 1'b0;
      rd_first_in   = rd_first_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      edge_valid_in = 1'b0;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      flag_in       = hit ? !flag_ff : flag_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      // A vertex read during the walk arrives in the cycle after its address is issued.
      if (rd_pend_ff) begin
         prev_x_in = rd_x;
         prev_y_in = rd_y;
         if (rd_first_ff) begin
            first_x_in = rd_x;
            first_y_in = rd_y;
         end else begin
            edge_valid_in = 1'b1;
            sx_in = prev_x_ff;
            sy_in = prev_y_ff;
            ex_in = rd_x;
            ey_in = rd_y;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  pip_pkg::OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_in.status = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  pip_pkg::OP_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     count_in     = '0;
                  end
                  pip_pkg::OP_QUERY: begin
                     px_in   = cmd.x;
                     py_in   = cmd.y;
                     flag_in = 1'b0;
                     // Fewer than two vertices never produce a crossing.
                     if (closed && count_ff > pip_pkg::CNT_W'(1)) begin
                        rd_idx_in = '0;
                        state_in  = S_WALK;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  pip_pkg::OP_NOP: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_WALK: begin
            rd_en       = 1'b1;
            rd_pend_in  = 1'b1;
            rd_first_in = (rd_idx_ff == '0);
            rd_idx_in   = rd_idx_ff + 1'b1;
            if (rd_idx_ff == pip_pkg::IDX_W'(count_ff - 1'b1)) begin
               state_in = S_CLOSE;
            end
         end
         S_CLOSE: begin
            // The last vertex arrives in this cycle.
            state_in = S_WRAP;
         end
         S_WRAP: begin
            // Closing edge from the last vertex back to the first.
            edge_valid_in = 1'b1;
            sx_in    = prev_x_ff;
            sy_in    = prev_y_ff;
            ex_in    = first_x_ff;
            ey_in    = first_y_ff;
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!edge_valid_ff && !prod_valid_ff) begin
               rsp_valid_in      = 1'b1;
               rsp_in.inside_res = flag_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rd_pend_ff    <= 1'b0;
         edge_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         flag_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_pend_ff    <= rd_pend_in;
         edge_valid_ff <= edge_valid_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         flag_ff       <= flag_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      rd_first_ff <= rd_first_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      first_x_ff  <= first_x_in;
      first_y_ff  <= first_y_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      cross_ff    <= cross_in;
      dpos_ff     <= dpos_in;
      lhs_ff      <= lhs_in;
      rhs_ff      <= rhs_in;
      rsp_ff      <= rsp_in;
   end

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the point-in-polygon tester: directed and random transactions.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pip_pkg::*;

   localparam int                CLK_HALF    = 4;
   localparam int                RANDOM_GOAL = 1200;
   localparam logic [CSR_ADDR_W-1:0] CLOSED_ADDR = CSR_ADDR_W'(4 * CSR_IDX_CLOSED);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Predictor state: vertex table, vertex count and the closed register.
   logic signed [COORD_W-1:0] poly_x [MAX_VERTICES];
   logic signed [COORD_W-1:0] poly_y [MAX_VERTICES];
   int                        poly_count = 0;
   logic                      closed_cfg = 1'b0;

   // Results still owed by the block, oldest first.
   rsp_type verdicts_due [$];

   int errors = 0;
   int sent_items = 0;
   int n_add = 0, n_dropped = 0, n_clear = 0, n_query = 0, n_inside = 0, n_unused = 0;
   int n_cfg = 0;

   point_in_polygon_test_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #(CLK_HALF) clock = ~clock;

   // Exact crossing test of a rightward ray from (px,py) against edge s->e.
   function automatic bit ray_crosses_edge(longint px, longint py, longint sx, longint sy,
                                           longint ex, longint ey);
      longint d;
      longint lhs;
      longint rhs;
      if ((sy > py) == (ey > py))
         return 1'b0;
      d   = ey - sy;
      lhs = (px - sx) * d;
      rhs = (ex - sx) * (py - sy);
      if (d > 0)
         return lhs < rhs;
      return lhs > rhs;
   endfunction

   // Applies one request to the predictor state and returns the verdict it should produce.
   function automatic rsp_type evaluate_request(req_type r);
      rsp_type v;
      int      i;
      int      j;
      v = '0;
      case (r.func)
         FUNC_ADD: begin
            n_add++;
            if (poly_count < MAX_VERTICES) begin
               poly_x[poly_count] = r.x;
               poly_y[poly_count] = r.y;
               poly_count++;
            end else begin
               v.status = 1'b1;
               n_dropped++;
            end
         end
         FUNC_CLEAR: begin
            n_clear++;
            poly_count = 0;
         end
         FUNC_QUERY: begin
            n_query++;
            if (closed_cfg) begin
               for (i = 0; i < poly_count; i++) begin
                  j = (i + 1 == poly_count) ? 0 : i + 1;
                  if (ray_crosses_edge(r.x, r.y, poly_x[i], poly_y[i], poly_x[j], poly_y[j]))
                     v.inside_res = ~v.inside_res;
               end
            end
            if (v.inside_res)
               n_inside++;
         end
         default: begin
            n_unused++;
         end
      endcase
      return v;
   endfunction

   // Compares every result strobe against the oldest outstanding verdict.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (verdicts_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual inside_res=%0b status=%0b",
                     $time, rsp_data.inside_res, rsp_data.status);
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_data.inside_res !== want.inside_res) begin
               errors++;
               $display("%0t: inside_res mismatch: expected %0b, actual %0b",
                        $time, want.inside_res, rsp_data.inside_res);
            end
            if (rsp_data.status !== want.status) begin
               errors++;
               $display("%0t: status mismatch: expected %0b, actual %0b",
                        $time, want.status, rsp_data.status);
            end
         end
      end
   end

   // Sends one request, then idles a random number of cycles. With no idle the
   // start line stays high so the next request follows back to back.
   task automatic send_item(input logic [1:0] func, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
      req_type r;
      int      gap;
      r.func = func;
      r.x    = x;
      r.y    = y;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      verdicts_due.push_back(evaluate_request(r));
      sent_items++;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lowers start and waits until every owed result has arrived.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (verdicts_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the closed register while idle and reads it back.
   task automatic write_closed(input logic value);
      drain_results();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CLOSED_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      closed_cfg = value;
      n_cfg++;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      // Read-back transaction.
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      if (prdata[0] !== value) begin
         errors++;
         $display("%0t: closed read-back mismatch: expected %0b, actual %0b",
                  $time, value, prdata[0]);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord(bit wide);
      logic signed [COORD_W-1:0] c;
      if (wide) begin
         c = COORD_W'($urandom);
      end else begin
         c = COORD_W'($urandom_range(0, 511));
         c = c - 16'sd256;
      end
      return c;
   endfunction

   // With the polygon open every query must answer outside.
   task automatic test_open_polygon();
      write_closed(1'b0);
      send_item(FUNC_CLEAR, 16'sd0, 16'sd0);
      send_item(FUNC_ADD, 16'sd0, 16'sd0);
      send_item(FUNC_ADD, 16'sd160, 16'sd0);
      send_item(FUNC_ADD, 16'sd0, 16'sd160);
      send_item(FUNC_QUERY, 16'sd16, 16'sd16);
      send_item(FUNC_NONE, -16'sd1, -16'sd1);
   endtask

   // Closed polygon: triangle, empty and single-vertex tables, extreme square.
   task automatic test_closed_cases();
      write_closed(1'b1);
      send_item(FUNC_QUERY, 16'sd16, 16'sd16);
      send_item(FUNC_QUERY, 16'sd200, 16'sd16);
      send_item(FUNC_CLEAR, 16'sd0, 16'sd0);
      send_item(FUNC_QUERY, 16'sd0, 16'sd0);
      send_item(FUNC_ADD, 16'sd5, 16'sd5);
      send_item(FUNC_QUERY, 16'sd0, 16'sd5);
      send_item(FUNC_CLEAR, 16'sd0, 16'sd0);
      // Square spanning the full coordinate range; its top and bottom edges are horizontal.
      send_item(FUNC_ADD, -16'sd32768, -16'sd32768);
      send_item(FUNC_ADD, 16'sd32767, -16'sd32768);
      send_item(FUNC_ADD, 16'sd32767, 16'sd32767);
      send_item(FUNC_ADD, -16'sd32768, 16'sd32767);
      send_item(FUNC_QUERY, 16'sd0, 16'sd0);
      send_item(FUNC_QUERY, -16'sd32768, 16'sd0);
      send_item(FUNC_QUERY, 16'sd32767, 16'sd32767);
      send_item(FUNC_QUERY, 16'sd0, 16'sd32767);
      send_item(FUNC_QUERY, -16'sd32768, -16'sd32768);
      send_item(FUNC_NONE, 16'sd0, 16'sd0);
   endtask

   // Random polygons with queries, occasional overflow of the table and noise.
   task automatic test_random_polygons();
      int  seq;
      int  kind;
      int  nv;
      int  nq;
      int  k;
      int  pick;
      bit  wide;
      logic signed [COORD_W-1:0] qy;
      seq = 0;
      while (sent_items < RANDOM_GOAL) begin
         if (seq % 8 == 0)
            write_closed(($urandom_range(0, 4) != 0) ? 1'b1 : 1'b0);
         kind = $urandom_range(0, 9);
         wide = ($urandom_range(0, 3) == 0);
         if (kind == 9 && seq != 0) begin
            // Noise: any function code with unconstrained coordinates.
            repeat (4)
               send_item(2'($urandom), COORD_W'($urandom), COORD_W'($urandom));
         end else begin
            if (seq == 0)
               nv = MAX_VERTICES + 3;
            else if (kind < 7)
               nv = $urandom_range(3, 10);
            else if (kind == 7)
               nv = $urandom_range(0, 2);
            else
               nv = $urandom_range(11, MAX_VERTICES + 4);
            if ($urandom_range(0, 5) != 0)
               send_item(FUNC_CLEAR, rand_coord(1'b1), rand_coord(1'b1));
            for (k = 0; k < nv; k++)
               send_item(FUNC_ADD, rand_coord(wide), rand_coord(wide));
            nq = $urandom_range(3, 12);
            for (k = 0; k < nq; k++) begin
               // Some rays pass exactly through a stored vertex.
               if (poly_count > 0 && $urandom_range(0, 3) == 0) begin
                  pick = $urandom_range(0, poly_count - 1);
                  qy   = poly_y[pick];
               end else begin
                  qy = rand_coord(wide);
               end
               send_item(FUNC_QUERY, rand_coord(wide), qy);
            end
         end
         // Now and then let the block empty out completely before going on.
         if ($urandom_range(0, 7) == 0)
            drain_results();
         seq++;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_open_polygon();
      test_closed_cases();
      test_random_polygons();
      drain_results();
      repeat (20) @(posedge clock);
      $display("Ran %0d transactions: %0d adds (%0d dropped on a full table), %0d clears,",
               sent_items, n_add, n_dropped, n_clear);
      $display("%0d queries (%0d inside), %0d unused codes; closed written %0d times.",
               n_query, n_inside, n_unused, n_cfg);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #6_000_000;
      $display("Timeout with %0d results outstanding.", verdicts_due.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
